@@ design/multicore_resync_barrier_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the resync barrier modules.
// Both expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MULTICORE_RESYNC_BARRIER_MACROS_SVH
`define MULTICORE_RESYNC_BARRIER_MACROS_SVH

// same-cycle implication
`define MRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrb_pkg
// Types and constants of the multicore resync barrier.
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

	localparam int MAX_CORES = 64;
	localparam int IDX_W     = $clog2(MAX_CORES);
	localparam int NUM_W     = $clog2(MAX_CORES + 1);

	localparam int COUNT_W   = 32;
	localparam int WINDOW_W  = 16;
	localparam int CORE_W    = 7;
	localparam int MODE_W    = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_WINDOW = 2'd2;

	localparam logic [MODE_W-1:0]   RST_SYNC_MODE     = 2'd1;
	localparam logic [CORE_W-1:0]   RST_CORE_COUNT    = 7'd4;
	localparam logic [WINDOW_W-1:0] RST_RESYNC_WINDOW = 16'd1024;

	// synchronization strategies
	localparam logic [MODE_W-1:0] MODE_WINDOWED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STAKH    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NOBIGGIE = 2'd2;

	// request functions
	localparam logic [1:0] FUNC_QUERY  = 2'd0;
	localparam logic [1:0] FUNC_RESYNC = 2'd1;
	localparam logic [1:0] FUNC_POLL   = 2'd2;
	localparam logic [1:0] FUNC_NEWFN  = 2'd3;

	typedef logic [1:0] flag_t;
	localparam flag_t FLAG_IDLE  = 2'd0;
	localparam flag_t FLAG_DONE  = 2'd1;
	localparam flag_t FLAG_MOVED = 2'd2;

	typedef struct packed {
		logic [5:0]         core_id;
		logic [1:0]         func;
		logic [COUNT_W-1:0] function_count;
		logic [COUNT_W-1:0] fn_version;
		logic               search_success;
	} in_item_t;

	typedef struct packed {
		logic               go_resync;
		logic               retry;
		logic               adopt_shared;
		logic               advance_function;
		logic [COUNT_W-1:0] shared_version;
		logic [COUNT_W-1:0] shared_count;
		logic               released;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic own_rd;
		logic own_wr;
		logic rem_start;
		logic scan_run;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic rem_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ design/mrb_rem.sv @@
// ----------------------------------------------------------------------------
// mrb_rem
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_rem (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [mrb_pkg::WINDOW_W-1:0]     divisor,
	input  wire [mrb_pkg::COUNT_W-1:0]      dividend,
	output logic                            busy,
	output logic                            rem_zero
);
	import mrb_pkg::*;

	localparam int STEP_W = $clog2(COUNT_W);

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [WINDOW_W-1:0] r_q;
	logic [COUNT_W-1:0]  x_q;

	logic [WINDOW_W:0] trial;
	logic [WINDOW_W:0] diff;
	logic              ge;

	assign trial = {r_q, x_q[COUNT_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(COUNT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the low bits
			r_q <= ge ? diff[WINDOW_W-1:0] : trial[WINDOW_W-1:0];
			x_q <= {x_q[COUNT_W-2:0], 1'b0};
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (r_q == '0);

endmodule

`default_nettype wire

@@ design/mrb_datapath.sv @@
// ----------------------------------------------------------------------------
// mrb_datapath
// Config registers, flag memory with valid bits, flag scan, remainder unit,
// published values and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [mrb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire [mrb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire mrb_pkg::in_item_t           in_data,
	output mrb_pkg::out_item_t               out_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	input  wire mrb_pkg::ctrl_cmd_t          cmd,
	output mrb_pkg::dp_sts_t                 sts
);
	import mrb_pkg::*;

	// configuration
	logic [MODE_W-1:0]   sync_mode_q;
	logic [CORE_W-1:0]   core_count_q;
	logic [WINDOW_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_mode_q  <= RST_SYNC_MODE;
			core_count_q <= RST_CORE_COUNT;
			window_q     <= RST_RESYNC_WINDOW;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SYNC_MODE:     sync_mode_q  <= cfg_wdata[MODE_W-1:0];
				CFG_CORE_COUNT:    core_count_q <= cfg_wdata[CORE_W-1:0];
				CFG_RESYNC_WINDOW: window_q     <= cfg_wdata[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	logic [NUM_W-1:0] num_eff;
	always_comb begin
		if (core_count_q == '0) begin
			num_eff = NUM_W'(1);
		end else if (int'(core_count_q) > MAX_CORES) begin
			num_eff = NUM_W'(MAX_CORES);
		end else begin
			num_eff = NUM_W'(core_count_q);
		end
	end

	// request
	in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	logic [IDX_W-1:0] id;
	logic             id_ok;
	logic             leader;
	assign id     = IDX_W'(item_q.core_id);
	assign id_ok  = NUM_W'(item_q.core_id) < num_eff;
	assign leader = (item_q.core_id == '0);

	// flag memory
	flag_t            flag_mem [MAX_CORES];
	logic [MAX_CORES-1:0] flag_vld_q;

	logic [NUM_W-1:0] scan_idx_q;
	logic             scan_issue;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	flag_t            rd_data_s1;
	logic             rd_vld_s1;
	flag_t            rd_flag;

	assign scan_issue = cmd.scan_run && (scan_idx_q < num_eff);
	assign rd_en      = cmd.own_rd || scan_issue;
	assign rd_addr    = cmd.own_rd ? id : scan_idx_q[IDX_W-1:0];
	assign rd_flag    = rd_vld_s1 ? rd_data_s1 : FLAG_IDLE;

	// own flag update, evaluated on the cycle the own read returns
	logic  own_we;
	flag_t own_new;
	always_comb begin
		own_we  = 1'b0;
		own_new = rd_flag;
		case (sync_mode_q)
			MODE_WINDOWED: begin
				if (item_q.func == FUNC_RESYNC) begin
					own_we  = 1'b1;
					own_new = FLAG_DONE;
				end else if (item_q.func == FUNC_NEWFN && leader) begin
					own_we  = (rd_flag == FLAG_MOVED);
					own_new = FLAG_IDLE;
				end
			end
			MODE_STAKH: begin
				if (item_q.func == FUNC_QUERY) begin
					own_we  = (rd_flag == FLAG_IDLE);
					own_new = FLAG_DONE;
				end else if (item_q.func == FUNC_RESYNC && !leader) begin
					own_we  = 1'b1;
					own_new = FLAG_MOVED;
				end
			end
			MODE_NOBIGGIE: begin
				if (item_q.func == FUNC_QUERY) begin
					own_we  = (rd_flag == FLAG_IDLE);
					own_new = FLAG_DONE;
				end else if (item_q.func == FUNC_RESYNC) begin
					own_we  = 1'b1;
					own_new = FLAG_MOVED;
				end
			end
			default: ;
		endcase
		own_we = own_we && id_ok;
	end

	// scan results and the own flag seen before the update
	flag_t own_q;
	logic  scan_pend_s1;
	logic [IDX_W-1:0] scan_ix_s1;
	logic  all_nz_q, all_one_q, fol_moved_q;
	flag_t flag0_q;

	// result decision
	logic rem_busy, rem_r_zero, rem_zero;
	assign rem_zero = (window_q == '0) ? (item_q.function_count == '0) : rem_r_zero;

	logic go, retry, adopt, adv, rel, do_clear, rel_win, publish, poll;
	always_comb begin
		go       = 1'b0;
		retry    = 1'b0;
		adopt    = 1'b0;
		adv      = 1'b0;
		rel      = 1'b0;
		do_clear = 1'b0;
		rel_win  = 1'b0;
		publish  = 1'b0;
		poll     = 1'b0;
		if (id_ok) begin
			case (sync_mode_q)
				MODE_WINDOWED: begin
					if (item_q.func == FUNC_QUERY) begin
						go = leader ? (rem_zero && own_q == FLAG_IDLE)
							: (flag0_q == FLAG_DONE && own_q == FLAG_IDLE);
					end else if (item_q.func == FUNC_RESYNC) begin
						if (leader) begin
							publish = 1'b1;
						end else begin
							adopt = 1'b1;
							if (all_one_q) begin
								do_clear = 1'b1;
								rel_win  = 1'b1;
								rel      = 1'b1;
							end
						end
					end
				end
				MODE_STAKH: begin
					if (item_q.func == FUNC_QUERY) begin
						go = leader ? (all_nz_q && fol_moved_q)
							: (all_nz_q && own_q != FLAG_MOVED);
					end else if (item_q.func == FUNC_RESYNC) begin
						adv = 1'b1;
						if (leader) begin
							do_clear = 1'b1;
							rel      = 1'b1;
						end
					end
				end
				MODE_NOBIGGIE: begin
					if (item_q.func == FUNC_QUERY) begin
						if (!item_q.search_success) begin
							go    = all_nz_q;
							retry = !all_nz_q;
						end
					end else if (item_q.func == FUNC_RESYNC) begin
						adv  = 1'b1;
						poll = leader;
					end else if (item_q.func == FUNC_POLL) begin
						poll = leader;
					end
					if (poll) begin
						if (fol_moved_q) begin
							do_clear = 1'b1;
							rel      = 1'b1;
						end else begin
							retry = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// single write port: own update, or leader flag after a windowed release
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	flag_t            mem_wd;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = id;
		mem_wd = own_new;
		if (cmd.own_wr && own_we) begin
			mem_we = 1'b1;
		end else if (cmd.finish && rel_win) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = FLAG_MOVED;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flag_mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_s1 <= flag_mem[rd_addr];
			rd_vld_s1  <= flag_vld_q[rd_addr];
		end
	end

	// a clear drops the valid bits of cores [0, n); a write in the same cycle wins
	logic [MAX_CORES-1:0] vld_next;
	always_comb begin
		vld_next = flag_vld_q;
		if (cmd.finish && do_clear) begin
			for (int i = 0; i < MAX_CORES; i++) begin
				if (NUM_W'(i) < num_eff) begin
					vld_next[i] = 1'b0;
				end
			end
		end
		if (mem_we) begin
			vld_next[mem_wa] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_vld_q <= '0;
		end else begin
			flag_vld_q <= vld_next;
		end
	end

	// scan over cores [0, n), one read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			scan_pend_s1 <= 1'b0;
		end else begin
			scan_pend_s1 <= scan_issue;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (scan_issue) begin
				scan_idx_q <= scan_idx_q + NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			scan_ix_s1 <= scan_idx_q[IDX_W-1:0];
		end
		if (cmd.own_wr) begin
			own_q <= rd_flag;
		end
		if (cmd.load) begin
			all_nz_q    <= 1'b1;
			all_one_q   <= 1'b1;
			fol_moved_q <= 1'b1;
			flag0_q     <= FLAG_IDLE;
		end else if (scan_pend_s1) begin
			all_nz_q  <= all_nz_q && (rd_flag != FLAG_IDLE);
			all_one_q <= all_one_q && (rd_flag == FLAG_DONE);
			if (scan_ix_s1 == '0) begin
				flag0_q <= rd_flag;
			end else begin
				fol_moved_q <= fol_moved_q && (rd_flag == FLAG_MOVED);
			end
		end
	end

	mrb_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.divisor  (window_q),
		.dividend (item_q.function_count),
		.busy     (rem_busy),
		.rem_zero (rem_r_zero)
	);

	// published values
	logic [COUNT_W-1:0] pub_ver_q, pub_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_ver_q <= '0;
			pub_cnt_q <= '0;
		end else if (cmd.finish && publish) begin
			pub_ver_q <= item_q.fn_version;
			pub_cnt_q <= item_q.function_count;
		end
	end

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.go_resync        <= go;
			out_q.retry            <= retry;
			out_q.adopt_shared     <= adopt;
			out_q.advance_function <= adv;
			out_q.shared_version   <= publish ? item_q.fn_version : pub_ver_q;
			out_q.shared_count     <= publish ? item_q.function_count : pub_cnt_q;
			out_q.released         <= rel;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign sts.scan_done = !scan_pend_s1 && (scan_idx_q == num_eff);
	assign sts.rem_done  = !rem_busy;
	assign sts.out_free  = !out_valid_q || out_ready;

	`include "multicore_resync_barrier_macros.svh"

	`MRB_ASSERT_IMP(a_scan_bound, cmd.scan_run, scan_idx_q <= num_eff, "scan ran past core count")
	`MRB_ASSERT_IMP(a_out_overwrite, cmd.finish, !out_valid_q || out_ready,
		"result overwrote an untaken result")

endmodule

`default_nettype wire

@@ design/mrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrb_ctrl
// Sequencer: own flag read/update, flag scan with the remainder unit, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output mrb_pkg::ctrl_cmd_t   cmd,
	input  wire mrb_pkg::dp_sts_t sts
);
	import mrb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_OWN,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_READ;
				ST_READ:   state_q <= ST_OWN;
				ST_OWN:    state_q <= ST_SCAN;
				ST_SCAN:   if (sts.scan_done && sts.rem_done) state_q <= ST_FINISH;
				ST_FINISH: if (sts.out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign cmd.load      = in_ready && in_valid;
	assign cmd.own_rd    = (state_q == ST_READ);
	assign cmd.own_wr    = (state_q == ST_OWN);
	assign cmd.rem_start = (state_q == ST_OWN);
	assign cmd.scan_run  = (state_q == ST_SCAN);
	assign cmd.finish    = (state_q == ST_FINISH) && sts.out_free;

	`include "multicore_resync_barrier_macros.svh"

	`MRB_ASSERT_IMP(a_finish_ready, cmd.finish, sts.scan_done && sts.rem_done,
		"result issued before scan or remainder finished")
	`MRB_ASSERT_NXT(a_load_read, cmd.load, state_q == ST_READ, "accepted item not read")
	`MRB_ASSERT_NXT(a_finish_idle, cmd.finish, in_ready, "no return to idle after result")

endmodule

`default_nettype wire

@@ design/multicore_resync_barrier.sv @@
// ----------------------------------------------------------------------------
// multicore_resync_barrier
// Shared coordinator answering resync queries from cores.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on in_valid/in_ready with an in_item_t payload; each
//    request gives exactly one result on out_valid/out_ready (out_item_t).
//  - Configuration: cfg_we writes cfg_wdata into register cfg_idx
//    (0 sync mode, 1 core count, 2 resync window); write only while idle.
//  - The flag scan reads one flag per cycle over the n effective cores,
//    and the remainder unit runs alongside it; the result is issued once
//    both are done.
//  - One request is in flight at a time; in_ready is high only when idle.
//  - A finished result sits in the output register; while the receiver
//    stalls, in_ready stays low once the next request reaches its result.
//  - Reset clears all core flags at once (per-core valid bits), the
//    published version and count, and loads the register defaults
//    (stakhanovist mode, 4 cores, window 1024). No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multicore_resync_barrier (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [mrb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire [mrb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire mrb_pkg::in_item_t           in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output mrb_pkg::out_item_t               out_data
);
	import mrb_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	mrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mrb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire
